>>> sv/led_driver_serial_sequencer_core_macros.svh
// ----------------------------------------------------------------------------
// led driver serial sequencer assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef LED_DRIVER_SERIAL_SEQUENCER_CORE_MACROS_SVH
`define LED_DRIVER_SERIAL_SEQUENCER_CORE_MACROS_SVH

// property must hold at every clock edge out of reset
`define LDS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// expression must never be true out of reset
`define LDS_ASSERT_NEVER(label, expr, msg) \
    `LDS_ASSERT(label, !(expr), msg)

`endif

>>> sv/lds_pkg.sv
// ----------------------------------------------------------------------------
// lds_pkg
// types, constants and microcode program of the led driver serial sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package lds_pkg;

    localparam int WORD_BITS    = 16;
    localparam int WORD_IN_W    = 16;
    localparam int CNT_W        = $clog2(WORD_BITS);
    localparam int ADDR_W       = 5;
    localparam int PROG_LEN     = 28;
    localparam logic [7:0] SPECIAL_WAIT = 8'd3;

    localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(WORD_BITS - 1);

    // commands
    localparam logic [1:0] CMD_NORMAL_WORD  = 2'd0;
    localparam logic [1:0] CMD_SPECIAL_WORD = 2'd1;
    localparam logic [1:0] CMD_NORMAL_MODE  = 2'd2;
    localparam logic [1:0] CMD_SPECIAL_MODE = 2'd3;

    // pin operations
    localparam logic [1:0] PIN_KEEP = 2'd0;
    localparam logic [1:0] PIN_LOW  = 2'd1;
    localparam logic [1:0] PIN_HIGH = 2'd2;
    localparam logic [1:0] PIN_DATA = 2'd3;

    // wait selects
    localparam logic [1:0] WAIT_ZERO    = 2'd0;
    localparam logic [1:0] WAIT_ONE     = 2'd1;
    localparam logic [1:0] WAIT_SPECIAL = 2'd2;
    localparam logic [1:0] WAIT_STEP    = 2'd3;

    // program entry points
    localparam logic [ADDR_W-1:0] ENTRY_NORMAL_WORD  = 5'd0;
    localparam logic [ADDR_W-1:0] ENTRY_SPECIAL_WORD = 5'd4;
    localparam logic [ADDR_W-1:0] ENTRY_NORMAL_MODE  = 5'd10;
    localparam logic [ADDR_W-1:0] ENTRY_SPECIAL_MODE = 5'd19;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] word;
        logic [7:0]  step_time;
    } t_in;

    typedef struct packed {
        logic       clk_level;
        logic       sdi_level;
        logic       latch_level;
        logic       oe_level;
        logic [7:0] wait_us;
        logic       last;
    } t_out;

    typedef struct packed {
        logic clk;
        logic sdi;
        logic le;
        logic oe;
    } t_pins;

    typedef struct packed {
        logic [1:0]        clk_op;
        logic [1:0]        sdi_op;
        logic [1:0]        le_op;
        logic [1:0]        oe_op;
        logic [1:0]        wait_sel;
        logic              last;
        logic              loop;
        logic [ADDR_W-1:0] target;
    } t_uword;

    function automatic t_uword mk(
        input logic [1:0]        clk_op,
        input logic [1:0]        sdi_op,
        input logic [1:0]        le_op,
        input logic [1:0]        oe_op,
        input logic [1:0]        wait_sel,
        input logic              last,
        input logic              loop,
        input logic [ADDR_W-1:0] target
    );
        t_uword u;
        u.clk_op   = clk_op;
        u.sdi_op   = sdi_op;
        u.le_op    = le_op;
        u.oe_op    = oe_op;
        u.wait_sel = wait_sel;
        u.last     = last;
        u.loop     = loop;
        u.target   = target;
        return u;
    endfunction

    function automatic t_uword ucode(input logic [ADDR_W-1:0] addr);
        t_uword u;
        unique case (addr)
            // normal word
            5'd0:  u = mk(PIN_LOW,  PIN_DATA, PIN_KEEP, PIN_KEEP, WAIT_ONE, 1'b0, 1'b0, 5'd0);
            5'd1:  u = mk(PIN_HIGH, PIN_KEEP, PIN_KEEP, PIN_KEEP, WAIT_ONE, 1'b0, 1'b1, 5'd0);
            5'd2:  u = mk(PIN_KEEP, PIN_KEEP, PIN_HIGH, PIN_KEEP, WAIT_ONE, 1'b0, 1'b0, 5'd0);
            5'd3:  u = mk(PIN_KEEP, PIN_KEEP, PIN_LOW,  PIN_KEEP, WAIT_ZERO, 1'b1, 1'b0, 5'd0);
            // special word
            5'd4:  u = mk(PIN_LOW,  PIN_DATA, PIN_KEEP, PIN_KEEP, WAIT_ONE, 1'b0, 1'b0, 5'd0);
            5'd5:  u = mk(PIN_HIGH, PIN_KEEP, PIN_KEEP, PIN_KEEP, WAIT_ONE, 1'b0, 1'b1, 5'd4);
            5'd6:  u = mk(PIN_LOW,  PIN_KEEP, PIN_HIGH, PIN_KEEP, WAIT_ONE, 1'b0, 1'b0, 5'd0);
            5'd7:  u = mk(PIN_KEEP, PIN_KEEP, PIN_LOW,  PIN_KEEP, WAIT_SPECIAL, 1'b0, 1'b0, 5'd0);
            5'd8:  u = mk(PIN_KEEP, PIN_KEEP, PIN_KEEP, PIN_LOW,  WAIT_SPECIAL, 1'b0, 1'b0, 5'd0);
            5'd9:  u = mk(PIN_KEEP, PIN_KEEP, PIN_KEEP, PIN_HIGH, WAIT_ZERO, 1'b1, 1'b0, 5'd0);
            // normal mode switch
            5'd10: u = mk(PIN_LOW,  PIN_KEEP, PIN_KEEP, PIN_HIGH, WAIT_STEP, 1'b0, 1'b0, 5'd0);
            5'd11: u = mk(PIN_HIGH, PIN_KEEP, PIN_KEEP, PIN_KEEP, WAIT_STEP, 1'b0, 1'b0, 5'd0);
            5'd12: u = mk(PIN_LOW,  PIN_KEEP, PIN_KEEP, PIN_LOW,  WAIT_STEP, 1'b0, 1'b0, 5'd0);
            5'd13: u = mk(PIN_HIGH, PIN_KEEP, PIN_KEEP, PIN_KEEP, WAIT_STEP, 1'b0, 1'b0, 5'd0);
            5'd14: u = mk(PIN_LOW,  PIN_KEEP, PIN_KEEP, PIN_HIGH, WAIT_STEP, 1'b0, 1'b0, 5'd0);
            5'd15: u = mk(PIN_HIGH, PIN_KEEP, PIN_KEEP, PIN_KEEP, WAIT_STEP, 1'b0, 1'b0, 5'd0);
            5'd16: u = mk(PIN_LOW,  PIN_KEEP, PIN_KEEP, PIN_KEEP, WAIT_STEP, 1'b0, 1'b0, 5'd0);
            5'd17: u = mk(PIN_HIGH, PIN_KEEP, PIN_KEEP, PIN_KEEP, WAIT_STEP, 1'b0, 1'b0, 5'd0);
            5'd18: u = mk(PIN_LOW,  PIN_KEEP, PIN_KEEP, PIN_KEEP, WAIT_STEP, 1'b1, 1'b0, 5'd0);
            // special mode switch
            5'd19: u = mk(PIN_LOW,  PIN_KEEP, PIN_KEEP, PIN_HIGH, WAIT_STEP, 1'b0, 1'b0, 5'd0);
            5'd20: u = mk(PIN_HIGH, PIN_KEEP, PIN_KEEP, PIN_KEEP, WAIT_STEP, 1'b0, 1'b0, 5'd0);
            5'd21: u = mk(PIN_LOW,  PIN_KEEP, PIN_KEEP, PIN_LOW,  WAIT_STEP, 1'b0, 1'b0, 5'd0);
            5'd22: u = mk(PIN_HIGH, PIN_KEEP, PIN_KEEP, PIN_HIGH, WAIT_STEP, 1'b0, 1'b0, 5'd0);
            5'd23: u = mk(PIN_LOW,  PIN_KEEP, PIN_KEEP, PIN_KEEP, WAIT_STEP, 1'b0, 1'b0, 5'd0);
            5'd24: u = mk(PIN_HIGH, PIN_KEEP, PIN_KEEP, PIN_KEEP, WAIT_STEP, 1'b0, 1'b0, 5'd0);
            5'd25: u = mk(PIN_LOW,  PIN_KEEP, PIN_HIGH, PIN_KEEP, WAIT_STEP, 1'b0, 1'b0, 5'd0);
            5'd26: u = mk(PIN_HIGH, PIN_KEEP, PIN_KEEP, PIN_KEEP, WAIT_STEP, 1'b0, 1'b0, 5'd0);
            5'd27: u = mk(PIN_LOW,  PIN_KEEP, PIN_LOW,  PIN_KEEP, WAIT_STEP, 1'b1, 1'b0, 5'd0);
            default: u = mk(PIN_KEEP, PIN_KEEP, PIN_KEEP, PIN_KEEP, WAIT_ZERO, 1'b1, 1'b0, 5'd0);
        endcase
        return u;
    endfunction

    function automatic logic [ADDR_W-1:0] entry(input logic [1:0] command);
        logic [ADDR_W-1:0] a;
        unique case (command)
            CMD_NORMAL_WORD:  a = ENTRY_NORMAL_WORD;
            CMD_SPECIAL_WORD: a = ENTRY_SPECIAL_WORD;
            CMD_NORMAL_MODE:  a = ENTRY_NORMAL_MODE;
            CMD_SPECIAL_MODE: a = ENTRY_SPECIAL_MODE;
            default:          a = ENTRY_NORMAL_WORD;
        endcase
        return a;
    endfunction

    // zero-extend or truncate the input word to the shift length
    function automatic logic [WORD_BITS-1:0] fit_word(input logic [WORD_IN_W-1:0] w);
        logic [WORD_BITS+WORD_IN_W-1:0] ext;
        ext = {{WORD_BITS{1'b0}}, w};
        return ext[WORD_BITS-1:0];
    endfunction

    function automatic logic apply_pin(
        input logic [1:0] op,
        input logic       cur,
        input logic       data
    );
        logic v;
        case (op)
            PIN_LOW:  v = 1'b0;
            PIN_HIGH: v = 1'b1;
            PIN_DATA: v = data;
            default:  v = cur;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> sv/lds_seq.sv
// ----------------------------------------------------------------------------
// lds_seq
// microcode sequencer: program counter, bit loop counter and program table
// ----------------------------------------------------------------------------
`default_nettype none

module lds_seq (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_start,
    input  wire [1:0]               i_command,
    input  wire                     i_adv,
    output logic                    o_busy,
    output lds_pkg::t_uword         o_uword
);
    import lds_pkg::*;

    logic              r_busy;
    logic              n_busy;
    logic [ADDR_W-1:0] r_pc;
    logic [ADDR_W-1:0] n_pc;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    t_uword            cw;

    assign cw      = ucode(r_pc);
    assign o_uword = cw;
    assign o_busy  = r_busy;

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_pc   = entry(i_command);
            n_cnt  = CNT_INIT;
        end else if (i_adv) begin
            if (cw.last) begin
                n_busy = 1'b0;
            end
            if (cw.loop && (r_cnt != '0)) begin
                n_pc  = cw.target;
                n_cnt = r_cnt - CNT_W'(1);
            end else begin
                n_pc = r_pc + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
            r_cnt  <= n_cnt;
        end
    end

`include "led_driver_serial_sequencer_core_macros.svh"

    `LDS_ASSERT(a_last_ends, (i_adv && cw.last) |=> !r_busy, "busy after last step")
    `LDS_ASSERT_NEVER(a_pc_range, r_busy && (r_pc >= ADDR_W'(PROG_LEN)), "pc out of program")
    `LDS_ASSERT(a_cnt_load, $rose(r_busy) |-> (r_cnt == CNT_INIT), "bit counter not loaded")
    `LDS_ASSERT_NEVER(a_adv_idle, i_adv && !r_busy, "step while idle")

endmodule

`default_nettype wire

>>> sv/led_driver_serial_sequencer_core.sv
// ----------------------------------------------------------------------------
// led_driver_serial_sequencer_core
// pin phase sequencer for a serial-in latched led driver
// ----------------------------------------------------------------------------
// first phase: the command transfer sets the sequencer busy, then the phase is registered out
// throughput: one phase per cycle unless the output stalls; a word command
// shifts WORD_BITS data bits in a loop set by the bit counter
// next command is taken the cycle after the last phase is issued
// reset: synchronous, clk sdi le low, oe high, sequencer idle
// ----------------------------------------------------------------------------
`default_nettype none

module led_driver_serial_sequencer_core (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  wire lds_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output lds_pkg::t_out      o_out_data
);
    import lds_pkg::*;

    logic                 busy;
    logic                 start;
    logic                 adv;
    t_uword               cw;
    t_pins                r_pins;
    t_pins                n_pins;
    logic [WORD_BITS-1:0] r_word;
    logic [7:0]           r_step;
    t_out                 r_out;
    logic                 r_out_valid;
    logic [7:0]           wait_val;

    assign o_in_ready  = !busy;
    assign start       = i_in_valid && !busy;
    assign adv         = busy && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    lds_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_in_data.command),
        .i_adv     (adv),
        .o_busy    (busy),
        .o_uword   (cw)
    );

    always_comb begin
        n_pins.clk = apply_pin(cw.clk_op, r_pins.clk, 1'b0);
        n_pins.sdi = apply_pin(cw.sdi_op, r_pins.sdi, r_word[WORD_BITS-1]);
        n_pins.le  = apply_pin(cw.le_op,  r_pins.le,  1'b0);
        n_pins.oe  = apply_pin(cw.oe_op,  r_pins.oe,  1'b0);
        case (cw.wait_sel)
            WAIT_ONE:     wait_val = 8'd1;
            WAIT_SPECIAL: wait_val = SPECIAL_WAIT;
            WAIT_STEP:    wait_val = r_step;
            default:      wait_val = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pins      <= '{clk: 1'b0, sdi: 1'b0, le: 1'b0, oe: 1'b1};
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_pins      <= n_pins;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_word <= fit_word(i_in_data.word);
            r_step <= i_in_data.step_time;
        end else if (adv && (cw.sdi_op == PIN_DATA)) begin
            r_word <= {r_word[WORD_BITS-2:0], 1'b0};
        end
        if (adv) begin
            r_out.clk_level   <= n_pins.clk;
            r_out.sdi_level   <= n_pins.sdi;
            r_out.latch_level <= n_pins.le;
            r_out.oe_level    <= n_pins.oe;
            r_out.wait_us     <= wait_val;
            r_out.last        <= cw.last;
        end
    end

endmodule

`default_nettype wire
